FILE: src/tfu_pkg.sv
package tfu_pkg;

  // texel format codes
  localparam logic [3:0] FMT_RGBA5551 = 4'd0;
  localparam logic [3:0] FMT_RGBA8888 = 4'd1;
  localparam logic [3:0] FMT_I4       = 4'd2;
  localparam logic [3:0] FMT_I8       = 4'd3;
  localparam logic [3:0] FMT_IA4      = 4'd4;
  localparam logic [3:0] FMT_IA8      = 4'd5;
  localparam logic [3:0] FMT_IA16     = 4'd6;
  localparam logic [3:0] FMT_CI4      = 4'd7;
  localparam logic [3:0] FMT_CI8      = 4'd8;

  // register map
  localparam int PADDR_W = 3;
  localparam logic REG_TEXEL_FORMAT = 1'b0;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // one output pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] palette_index;
    logic       is_indexed;
    logic       last_of_run;
  } pixel_t;

  // pixels produced by one byte, p0 goes out first
  typedef struct packed {
    logic [1:0] cnt;
    pixel_t     p0;
    pixel_t     p1;
  } pair_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen4(input logic [3:0] v);
    widen4 = {v, v};
  endfunction

  // 3-bit intensity of an ia4 nibble, replicated to 8 bits
  function automatic logic [7:0] ia4_gray(input logic [3:0] nib);
    ia4_gray = {nib[3:1], nib[3:1], nib[3:2]};
  endfunction

  function automatic pixel_t gray_pixel(input logic [7:0] gray, input logic [7:0] alpha,
                                        input logic last);
    pixel_t p;
    p.red           = gray;
    p.green         = gray;
    p.blue          = gray;
    p.alpha         = alpha;
    p.palette_index = 8'd0;
    p.is_indexed    = 1'b0;
    p.last_of_run   = last;
    gray_pixel = p;
  endfunction

endpackage

FILE: src/tfu_cfg.sv
module tfu_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tfu_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [3:0]                  texel_format,
  output logic                        restart
);
  import tfu_pkg::*;

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_TEXEL_FORMAT);

  // a write to the format register restarts byte assembly at the same edge as the format update
  assign restart = wr_hit;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      texel_format <= FMT_RGBA5551;
    end else begin
      if (wr_hit) begin
        texel_format <= pwdata[3:0];
      end
    end
  end

  // readback
  always_comb begin
    prdata = 32'd0;
    if (paddr[PADDR_W-1] == REG_TEXEL_FORMAT) begin
      prdata = {28'd0, texel_format};
    end
  end

endmodule

FILE: src/tfu_unpack.sv
module tfu_unpack (
  input  logic           clk,
  input  logic           rst,
  input  logic [3:0]     texel_format,
  input  logic           restart,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     data_byte,
  input  logic           first_byte,
  input  logic           can_load,
  output logic           ld_valid,
  output tfu_pkg::pair_t ld
);
  import tfu_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_first;
  logic [1:0]  phase;
  logic [23:0] held;
  logic [1:0]  phase_next;
  logic [23:0] held_next;
  logic [1:0]  eff_phase;
  logic [23:0] eff_held;
  logic [3:0]  hi;
  logic [3:0]  lo;
  logic [15:0] v16;
  logic        adv;
  pair_t       res;

  assign hi        = in_byte[7:4];
  assign lo        = in_byte[3:0];
  assign eff_phase = in_first ? 2'd0 : phase;
  assign eff_held  = in_first ? 24'd0 : held;
  assign v16       = {eff_held[7:0], in_byte};

  // per-format unpack of the held byte
  always_comb begin
    res        = '0;
    phase_next = 2'd0;
    held_next  = 24'd0;
    case (texel_format)
      FMT_RGBA5551: begin
        if (eff_phase == 2'd0) begin
          phase_next = 2'd1;
          held_next  = {16'd0, in_byte};
        end else begin
          res.cnt              = 2'd1;
          res.p0.red           = widen5(v16[15:11]);
          res.p0.green         = widen5(v16[10:6]);
          res.p0.blue          = widen5(v16[5:1]);
          res.p0.alpha         = v16[0] ? ALPHA_OPAQUE : 8'd0;
          res.p0.last_of_run   = 1'b1;
        end
      end
      FMT_RGBA8888: begin
        if (eff_phase != 2'd3) begin
          phase_next = eff_phase + 2'd1;
          held_next  = {eff_held[15:0], in_byte};
        end else begin
          res.cnt            = 2'd1;
          res.p0.red         = eff_held[23:16];
          res.p0.green       = eff_held[15:8];
          res.p0.blue        = eff_held[7:0];
          res.p0.alpha       = in_byte;
          res.p0.last_of_run = 1'b1;
        end
      end
      FMT_I4: begin
        res.cnt = 2'd2;
        res.p0  = gray_pixel(widen4(hi), ALPHA_OPAQUE, 1'b0);
        res.p1  = gray_pixel(widen4(lo), ALPHA_OPAQUE, 1'b1);
      end
      FMT_I8: begin
        res.cnt = 2'd1;
        res.p0  = gray_pixel(in_byte, ALPHA_OPAQUE, 1'b1);
      end
      FMT_IA4: begin
        res.cnt = 2'd2;
        res.p0  = gray_pixel(ia4_gray(hi), hi[0] ? ALPHA_OPAQUE : 8'd0, 1'b0);
        res.p1  = gray_pixel(ia4_gray(lo), lo[0] ? ALPHA_OPAQUE : 8'd0, 1'b1);
      end
      FMT_IA8: begin
        res.cnt = 2'd1;
        res.p0  = gray_pixel(widen4(hi), widen4(lo), 1'b1);
      end
      FMT_IA16: begin
        if (eff_phase == 2'd0) begin
          phase_next = 2'd1;
          held_next  = {16'd0, in_byte};
        end else begin
          res.cnt = 2'd1;
          res.p0  = gray_pixel(eff_held[7:0], in_byte, 1'b1);
        end
      end
      FMT_CI4: begin
        res.cnt                 = 2'd2;
        res.p0                  = gray_pixel({hi, 4'd0}, ALPHA_OPAQUE, 1'b0);
        res.p0.palette_index    = {4'd0, hi};
        res.p0.is_indexed       = 1'b1;
        res.p1                  = gray_pixel({lo, 4'd0}, ALPHA_OPAQUE, 1'b1);
        res.p1.palette_index    = {4'd0, lo};
        res.p1.is_indexed       = 1'b1;
      end
      FMT_CI8: begin
        res.cnt              = 2'd1;
        res.p0               = gray_pixel(in_byte, ALPHA_OPAQUE, 1'b1);
        res.p0.palette_index = in_byte;
        res.p0.is_indexed    = 1'b1;
      end
      default: begin
        // unused code: byte dropped, assembly restarts
        res = '0;
      end
    endcase
  end

  // a byte with no pixels never waits for the output side
  assign adv      = in_valid && ((res.cnt == 2'd0) || can_load);
  assign s_tready = !in_valid || adv;
  assign ld_valid = adv && (res.cnt != 2'd0);
  assign ld       = res;

  // input register and assembly state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      phase    <= 2'd0;
      held     <= 24'd0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (restart) begin
        phase <= 2'd0;
        held  <= 24'd0;
      end else if (adv) begin
        phase <= phase_next;
        held  <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= data_byte;
      in_first <= first_byte;
    end
  end

endmodule

FILE: src/tfu_pair_buf.sv
module tfu_pair_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            ld_valid,
  input  tfu_pkg::pair_t  ld,
  output logic            can_load,
  output logic            m_tvalid,
  input  logic            m_tready,
  output tfu_pkg::pixel_t head
);
  import tfu_pkg::*;

  logic [1:0] cnt;
  pixel_t     p0;
  pixel_t     p1;
  logic       drain;

  assign m_tvalid = (cnt != 2'd0);
  assign drain    = m_tvalid && m_tready;
  assign can_load = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);
  assign head     = p0;

  // pixel count; a load replaces whatever is left after this cycle's transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (ld_valid) begin
      cnt <= ld.cnt;
    end else if (drain) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_valid) begin
      p0 <= ld.p0;
      p1 <= ld.p1;
    end else if (drain && (cnt == 2'd2)) begin
      p0 <= p1;
    end
  end

endmodule

FILE: src/texel_format_unpack_core.sv
// Texel format unpacker: raw texture bytes in, 8-bit RGBA pixels out.
// Input stream: s_tdata carries one byte in memory order, s_tuser marks the
// first byte of a texture and restarts byte assembly.
// Output stream: one pixel per transaction; tdata packs red, green, blue,
// alpha and palette index, tuser flags indexed formats, tlast marks the last
// pixel produced by a byte.
// APB port: one register, texel_format at address 0. Writing it restarts
// byte assembly; write it only while both streams are idle.
// Pipeline: two register stages, the input register and the pixel pair
// register; an accepted byte is unpacked on its way from one to the other.
// Throughput: one byte per cycle for 8/16/32-bit formats while the receiver
// does not stall; 4-bit formats give two pixels per byte, and their byte rate
// is set by the single output port draining the pixel pair register one pixel per cycle.
// When the receiver stalls, the pair register holds and the input register
// fills, then s_tready drops; nothing is lost.
// Reset (rst, synchronous): format rgba5551, assembly cleared, both streams
// empty.
module texel_format_unpack_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] data_byte
  input  logic                        s_tuser,   // [0] first_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [39:0]                 m_tdata,   // red, green, blue, alpha, palette_index
  output logic                        m_tuser,   // [0] is_indexed
  output logic                        m_tlast,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tfu_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tfu_pkg::*;

  logic [3:0] texel_format;
  logic       restart;
  logic       can_load;
  logic       ld_valid;
  pair_t      ld;
  pixel_t     head;

  tfu_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .texel_format (texel_format),
    .restart      (restart)
  );

  tfu_unpack u_unpack (
    .clk          (clk),
    .rst          (rst),
    .texel_format (texel_format),
    .restart      (restart),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .data_byte    (s_tdata),
    .first_byte   (s_tuser),
    .can_load     (can_load),
    .ld_valid     (ld_valid),
    .ld           (ld)
  );

  tfu_pair_buf u_pair_buf (
    .clk      (clk),
    .rst      (rst),
    .ld_valid (ld_valid),
    .ld       (ld),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = {head.palette_index, head.alpha, head.blue, head.green, head.red};
  assign m_tuser = head.is_indexed;
  assign m_tlast = head.last_of_run;

endmodule

FILE: src/tfu_checker.sv
module tfu_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [39:0]                 m_tdata,
  input logic                        m_tuser,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [tfu_pkg::PADDR_W-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);

  // output stream is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // stalled pixel holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled pixel changed");

  // indexed pixels are opaque
  a_indexed_opaque: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[31:24] == 8'hFF)
    else $error("indexed pixel not opaque");

  // palette index is zero outside indexed formats
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[39:32] == 8'd0)
    else $error("palette index set on non-indexed pixel");

  // a format write reads back at the same address
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && !paddr[tfu_pkg::PADDR_W-1]
    |=> (paddr != $past(paddr)) || (prdata[3:0] == $past(pwdata[3:0])))
    else $error("format register readback mismatch");

endmodule

bind texel_format_unpack_core tfu_checker u_tfu_checker (.*);

FILE: tb/sv/texel_format_unpack_core_tb.sv
`timescale 1ns / 100ps

module texel_format_unpack_core_tb;
  import tfu_pkg::*;

  // format codes the block does not define; bytes are dropped there
  localparam logic [3:0] FMT_UNUSED_FIRST = 4'd9;
  localparam logic [3:0] FMT_UNUSED_LAST  = 4'd15;

  localparam logic [PADDR_W-1:0] ADDR_TEXEL_FORMAT = {REG_TEXEL_FORMAT, 2'b00};

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tuser = 1'b0;    // [0] first_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;           // [7:0] red, [15:8] green, [23:16] blue,
                                  // [31:24] alpha, [39:32] palette_index
  logic        m_tuser;           // [0] is_indexed
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  texel_format_unpack_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // unpacker state as predicted from the accepted bytes
  logic [3:0]  fmt_reg = FMT_RGBA5551;
  logic [1:0]  asm_phase = 2'd0;
  logic [23:0] asm_bytes = 24'd0;
  pixel_t      expected_pixels[$];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int pixels_checked = 0;
  int format_writes = 0;
  int cycle_count = 0;

  function automatic pixel_t make_pixel(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [7:0] a,
                                        input logic [7:0] idx, input logic indexed,
                                        input logic last);
    pixel_t p;
    p.red           = r;
    p.green         = g;
    p.blue          = b;
    p.alpha         = a;
    p.palette_index = idx;
    p.is_indexed    = indexed;
    p.last_of_run   = last;
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%s", msg);
  endtask

  // expected pixels for one accepted byte, in output order
  task automatic unpack_texel_byte(input logic [7:0] d, input logic first);
    logic [3:0]  hi;
    logic [3:0]  lo;
    logic [15:0] w;
    logic [7:0]  gh;
    logic [7:0]  gl;
    hi = d[7:4];
    lo = d[3:0];
    if (first) begin
      asm_phase = 2'd0;
      asm_bytes = 24'd0;
    end
    case (fmt_reg)
      FMT_RGBA5551: begin
        if (asm_phase == 2'd0) begin
          asm_bytes = {16'd0, d};
          asm_phase = 2'd1;
        end else begin
          w = {asm_bytes[7:0], d};
          asm_phase = 2'd0;
          asm_bytes = 24'd0;
          expected_pixels.push_back(make_pixel({w[15:11], w[15:13]}, {w[10:6], w[10:8]},
                                               {w[5:1], w[5:3]}, w[0] ? 8'hFF : 8'h00,
                                               8'h00, 1'b0, 1'b1));
        end
      end
      FMT_RGBA8888: begin
        if (asm_phase < 2'd3) begin
          asm_bytes = {asm_bytes[15:0], d};
          asm_phase = asm_phase + 2'd1;
        end else begin
          expected_pixels.push_back(make_pixel(asm_bytes[23:16], asm_bytes[15:8],
                                               asm_bytes[7:0], d, 8'h00, 1'b0, 1'b1));
          asm_phase = 2'd0;
          asm_bytes = 24'd0;
        end
      end
      FMT_I4: begin
        // full nibble replication, high nibble first
        expected_pixels.push_back(make_pixel({hi, hi}, {hi, hi}, {hi, hi}, ALPHA_OPAQUE,
                                             8'h00, 1'b0, 1'b0));
        expected_pixels.push_back(make_pixel({lo, lo}, {lo, lo}, {lo, lo}, ALPHA_OPAQUE,
                                             8'h00, 1'b0, 1'b1));
      end
      FMT_I8: begin
        expected_pixels.push_back(make_pixel(d, d, d, ALPHA_OPAQUE, 8'h00, 1'b0, 1'b1));
      end
      FMT_IA4: begin
        // 3-bit intensity replicated, low bit of the nibble is alpha
        gh = {hi[3:1], hi[3:1], hi[3:2]};
        gl = {lo[3:1], lo[3:1], lo[3:2]};
        expected_pixels.push_back(make_pixel(gh, gh, gh, hi[0] ? 8'hFF : 8'h00,
                                             8'h00, 1'b0, 1'b0));
        expected_pixels.push_back(make_pixel(gl, gl, gl, lo[0] ? 8'hFF : 8'h00,
                                             8'h00, 1'b0, 1'b1));
      end
      FMT_IA8: begin
        expected_pixels.push_back(make_pixel({hi, hi}, {hi, hi}, {hi, hi}, {lo, lo},
                                             8'h00, 1'b0, 1'b1));
      end
      FMT_IA16: begin
        if (asm_phase == 2'd0) begin
          asm_bytes = {16'd0, d};
          asm_phase = 2'd1;
        end else begin
          gh = asm_bytes[7:0];
          asm_phase = 2'd0;
          asm_bytes = 24'd0;
          expected_pixels.push_back(make_pixel(gh, gh, gh, d, 8'h00, 1'b0, 1'b1));
        end
      end
      FMT_CI4: begin
        expected_pixels.push_back(make_pixel({hi, 4'h0}, {hi, 4'h0}, {hi, 4'h0},
                                             ALPHA_OPAQUE, {4'h0, hi}, 1'b1, 1'b0));
        expected_pixels.push_back(make_pixel({lo, 4'h0}, {lo, 4'h0}, {lo, 4'h0},
                                             ALPHA_OPAQUE, {4'h0, lo}, 1'b1, 1'b1));
      end
      FMT_CI8: begin
        expected_pixels.push_back(make_pixel(d, d, d, ALPHA_OPAQUE, d, 1'b1, 1'b1));
      end
      default: begin
        // unused code: byte dropped, assembly restarts
        asm_phase = 2'd0;
        asm_bytes = 24'd0;
      end
    endcase
    // single-byte formats leave nothing held
    if (fmt_reg != FMT_RGBA5551 && fmt_reg != FMT_RGBA8888 && fmt_reg != FMT_IA16) begin
      asm_phase = 2'd0;
      asm_bytes = 24'd0;
    end
  endtask

  // one byte transaction with a random gap ahead of it
  task automatic send_byte(input logic [7:0] d, input logic first);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    unpack_texel_byte(d, first);
    bytes_sent++;
  endtask

  // stop sending and let every expected pixel drain out
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB setup and access phase
  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_TEXEL_FORMAT;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) begin
      fmt_reg   = wdata[3:0];
      asm_phase = 2'd0;
      asm_bytes = 24'd0;
      format_writes++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_format_readback();
    logic [31:0] rd;
    apb_access(1'b0, 32'h0, rd);
    if (rd[3:0] !== fmt_reg)
      report_mismatch($sformatf("texel_format readback: expected %0d, got %0d",
                                fmt_reg, rd[3:0]));
  endtask

  // write the format with random upper bits, then read it back
  task automatic set_texel_format(input logic [3:0] fmt);
    logic [31:0] rnd;
    logic [31:0] rd;
    rnd = $urandom;
    apb_access(1'b1, {rnd[31:4], fmt}, rd);
    check_format_readback();
  endtask

  // pixel checker
  pixel_t got_px;
  pixel_t want_px;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_px = make_pixel(m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24],
                          m_tdata[39:32], m_tuser, m_tlast);
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("cycle %0d: pixel with none expected: tdata=%010h user=%0b last=%0b",
                                  cycle_count, m_tdata, m_tuser, m_tlast));
      end else begin
        want_px = expected_pixels.pop_front();
        pixels_checked++;
        if (got_px !== want_px)
          report_mismatch($sformatf({"cycle %0d: expected rgba=%02h%02h%02h%02h idx=%02h ",
                                     "ind=%0b last=%0b, got rgba=%02h%02h%02h%02h idx=%02h ",
                                     "ind=%0b last=%0b"}, cycle_count,
                                    want_px.red, want_px.green, want_px.blue, want_px.alpha,
                                    want_px.palette_index, want_px.is_indexed,
                                    want_px.last_of_run, got_px.red, got_px.green,
                                    got_px.blue, got_px.alpha, got_px.palette_index,
                                    got_px.is_indexed, got_px.last_of_run));
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_register_readback();
    check_format_readback();
  endtask

  // every format with channel extremes
  task automatic test_each_format();
    set_texel_format(FMT_RGBA5551);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    wait_idle();
    // a write with one byte held must restart assembly
    set_texel_format(FMT_RGBA8888);
    send_byte(8'h55, 1'b1);
    wait_idle();
    set_texel_format(FMT_RGBA8888);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    wait_idle();
    set_texel_format(FMT_I4);
    send_byte(8'h1E, 1'b1);
    wait_idle();
    set_texel_format(FMT_I8);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    set_texel_format(FMT_IA4);
    send_byte(8'hE1, 1'b1);
    wait_idle();
    set_texel_format(FMT_IA8);
    send_byte(8'hF0, 1'b1);
    wait_idle();
    set_texel_format(FMT_IA16);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h80, 1'b0);
    wait_idle();
    set_texel_format(FMT_CI4);
    send_byte(8'hF0, 1'b1);
    wait_idle();
    set_texel_format(FMT_CI8);
    send_byte(8'hA5, 1'b1);
    wait_idle();
  endtask

  // first_byte in the middle of a texel drops the held byte
  task automatic test_first_byte_restart();
    set_texel_format(FMT_RGBA5551);
    send_byte(8'hAB, 1'b1);
    send_byte(8'hCD, 1'b1);
    send_byte(8'hEF, 1'b0);
    wait_idle();
  endtask

  // undefined format codes give nothing
  task automatic test_unused_format();
    set_texel_format(FMT_UNUSED_LAST);
    send_byte(8'h00, 1'b0);
    wait_idle();
    set_texel_format(FMT_UNUSED_FIRST);
    send_byte(8'hFF, 1'b1);
    wait_idle();
  endtask

  // random textures in random formats under one handshake pressure setting
  task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                    input int n_bytes);
    int          sent;
    int          seg;
    int          texel_len;
    bit          paused;
    logic [3:0]  fmt;
    logic [7:0]  d;
    logic        first;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_bytes) begin
      wait_idle();
      if ($urandom_range(11) == 0) fmt = 4'($urandom_range(FMT_UNUSED_FIRST, FMT_UNUSED_LAST));
      else fmt = 4'($urandom_range(FMT_RGBA5551, FMT_CI8));
      set_texel_format(fmt);
      case (fmt)
        FMT_RGBA5551, FMT_IA16: texel_len = 2;
        FMT_RGBA8888:           texel_len = 4;
        default:                texel_len = 1;
      endcase
      seg = (fmt > FMT_CI8) ? 6 : $urandom_range(16, 60);
      for (int i = 0; i < seg; i++) begin
        case ($urandom_range(9))
          0:       d = 8'h00;
          1:       d = 8'hFF;
          default: d = 8'($urandom);
        endcase
        // texture starts on texel boundaries; rare stray marks mid-texel
        first = (i == 0) || ((i % texel_len) == 0 && $urandom_range(19) == 0) ||
                ($urandom_range(39) == 0);
        send_byte(d, first);
        if (!paused && i == seg / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
      if (fmt <= FMT_CI8) sent += seg;
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_register_readback();
    test_each_format();
    test_first_byte_restart();
    test_unused_format();
    test_random_stream(0, 0, 335);
    test_random_stream(84, 0, 335);
    test_random_stream(0, 84, 335);
    test_random_stream(37, 37, 335);
    wait_idle();
    repeat (12) @(posedge clk);
    $display("covered %0d texture bytes, %0d pixels checked, %0d format register writes",
             bytes_sent, pixels_checked, format_writes);
    $display("all nine formats plus unused codes, under four idle and backpressure mixes");
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
src/tfu_pkg.sv
src/tfu_cfg.sv
src/tfu_unpack.sv
src/tfu_pair_buf.sv
src/texel_format_unpack_core.sv
src/tfu_checker.sv
tb/sv/texel_format_unpack_core_tb.sv
